// ===== src/tqla_pkg.sv =====
`timescale 1ns / 1ps
package tqla_pkg;
    localparam int STATE_COUNT_DEF = 64;
    localparam int ACTION_MAX_DEF  = 4;
    localparam int CFG_W  = 17;
    localparam int CFG_IW = 3;

    localparam logic [2:0] REG_ACTION_COUNT  = 3'd0;
    localparam logic [2:0] REG_LEARN_RATE    = 3'd1;
    localparam logic [2:0] REG_DISCOUNT      = 3'd2;
    localparam logic [2:0] REG_EXPLORE_FLOOR = 3'd3;
    localparam logic [2:0] REG_EXPLORE_DECAY = 3'd4;
    localparam logic [2:0] REG_EXPLORE_START = 3'd5;

    localparam logic [2:0]  ACTION_COUNT_RST  = 3'd4;
    localparam logic [15:0] LEARN_RATE_RST    = 16'd6554;
    localparam logic [15:0] DISCOUNT_RST      = 16'd62259;
    localparam logic [16:0] EXPLORE_FLOOR_RST = 17'd3277;
    localparam logic [15:0] EXPLORE_DECAY_RST = 16'd65208;
    localparam logic [16:0] EXPLORE_START_RST = 17'd65536;

    // controller to datapath commands
    typedef struct packed {
        logic load;        // capture input transaction
        logic clr_wr;      // clearing pass write
        logic rd_cur;      // issue read of current-state entry
        logic rd_nxt;      // issue read of next-state entry
        logic rd_old;      // issue read of pending entry
        logic scan_cur;    // fold returned current-state data (pass 1)
        logic pick_cur;    // fold returned current-state data (pass 2)
        logic scan_nxt;    // fold returned next-state data
        logic take_old;    // capture old value
        logic mul_g;       // gamma * max
        logic mul_a;       // alpha * diff
        logic mul_e;       // decay product
        logic wr_q;        // write back and commit pending/epsilon
        logic do_upd;      // update is taking place
        logic first;       // first element of a scan
        logic publish;     // load output register
    } tqla_cmd_t;

    typedef struct packed {
        logic explore;     // exploration decided
        logic upd_ok;      // pending decision valid and in range
    } tqla_sts_t;
endpackage

// ===== src/tqla_if.sv =====
`timescale 1ns / 1ps
interface tqla_in_if;
    logic        valid;
    logic        ready;
    logic [5:0]  current_state;
    logic [5:0]  following_state;
    logic signed [31:0] reward_value;
    logic [15:0] explore_draw;
    logic [15:0] pick_draw;
    modport source (output valid, current_state, following_state, reward_value,
                    explore_draw, pick_draw, input ready);
    modport sink (input valid, current_state, following_state, reward_value,
                  explore_draw, pick_draw, output ready);
endinterface

interface tqla_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  chosen_action;
    logic        explored;
    logic        update_done;
    logic signed [31:0] updated_value;
    modport source (output valid, chosen_action, explored, update_done, updated_value,
                    input ready);
    modport sink (input valid, chosen_action, explored, update_done, updated_value,
                  output ready);
endinterface

// ===== src/tabular_q_learning_agent_core.sv =====
`timescale 1ns / 1ps
// tabular q-learning agent: one decision transaction in, one result out.
// after reset a clearing pass zeroes the q table, one entry per cycle,
// all STATE_COUNT*ACTION_MAX entries (256 by default), before the first input
// is taken. each decision then runs through the single read port of the q
// table: a max/tie scan and a pick pass over the current state (skipped when
// exploring), then, if a valid pending update is held, a max pass over the
// next state, the read of the pending entry and two registered multiplies,
// then the write back. configuration writes are accepted whenever the block is idle.
module tabular_q_learning_agent_core #(
    parameter int STATE_COUNT = tqla_pkg::STATE_COUNT_DEF,
    parameter int ACTION_MAX  = tqla_pkg::ACTION_MAX_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    tqla_in_if.sink                       in_ch,
    tqla_out_if.source                    out_ch,
    input  logic                          cfg_we,
    input  logic [tqla_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [tqla_pkg::CFG_W-1:0]    cfg_data
);
    localparam int DEPTH = STATE_COUNT * ACTION_MAX;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(ACTION_MAX + 1);
    localparam int SW = (STATE_COUNT > 1) ? $clog2(STATE_COUNT) : 1;
    localparam int XW = 2;

    tqla_pkg::tqla_cmd_t cmd;
    tqla_pkg::tqla_sts_t sts;
    logic [NW-1:0] idx, n_used;
    logic [AW-1:0] clr_addr;

    // sequencer: clearing pass, table scans, multiply and write back
    tqla_ctrl #(.DEPTH(DEPTH), .AW(AW), .NW(NW)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .n_used    (n_used),
        .sts       (sts),
        .cmd       (cmd),
        .idx       (idx),
        .clr_addr  (clr_addr)
    );

    // datapath: q table, config, epsilon, fixed-point update
    tqla_dp #(
        .STATE_COUNT (STATE_COUNT),
        .ACTION_MAX  (ACTION_MAX),
        .AW (AW), .NW (NW), .SW (SW), .XW (XW)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .idx             (idx),
        .clr_addr        (clr_addr),
        .current_state   (in_ch.current_state),
        .following_state (in_ch.following_state),
        .reward_value    (in_ch.reward_value),
        .explore_draw    (in_ch.explore_draw),
        .pick_draw       (in_ch.pick_draw),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .n_used          (n_used),
        .chosen_action   (out_ch.chosen_action),
        .explored        (out_ch.explored),
        .update_done     (out_ch.update_done),
        .updated_value   (out_ch.updated_value)
    );

    // no new transaction while a result is still held
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !in_ch.ready)
        else $error("input taken while result pending");

    // an accepted transaction starts the scan in the following cycle
    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("block stayed ready after accepting");

    // updated_value is zero whenever a result is shown without update_done
    a_zero_no_upd: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.update_done) |-> (out_ch.updated_value == 32'sd0))
        else $error("value reported without update");
endmodule

// ===== src/tqla_ram.sv =====
`timescale 1ns / 1ps
module tqla_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== src/tqla_ctrl.sv =====
`timescale 1ns / 1ps
module tqla_ctrl #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int NW    = 3
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  logic [NW-1:0]        n_used,
    input  tqla_pkg::tqla_sts_t  sts,
    output tqla_pkg::tqla_cmd_t  cmd,
    output logic [NW-1:0]        idx,
    output logic [AW-1:0]        clr_addr
);
    typedef enum logic [9:0] {
        S_CLEAR = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_SCAN  = 10'b0000000100,
        S_PICK  = 10'b0000001000,
        S_NXT   = 10'b0000010000,
        S_OLD   = 10'b0000100000,
        S_MULG  = 10'b0001000000,
        S_MULA  = 10'b0010000000,
        S_WR    = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic [NW-1:0] idx_reg, idx_next;
    logic          rv_reg, rv_next;      // read data valid next cycle
    logic [AW-1:0] clr_reg, clr_next;
    logic          ov_reg, ov_next;

    assign idx      = idx_reg;
    assign clr_addr = clr_reg;
    assign out_valid = ov_reg;
    assign in_ready = (state_reg == S_IDLE) && !ov_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        rv_next    = 1'b0;
        clr_next   = clr_reg;
        ov_next    = ov_reg;
        cmd        = '0;
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load   = 1'b1;
                    idx_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // issue reads idx, consume previous
                cmd.scan_cur = rv_reg;
                cmd.first    = rv_reg && (idx_reg == NW'(1));
                if (idx_reg < n_used)
                begin
                    cmd.rd_cur = 1'b1;
                    rv_next    = 1'b1;
                    idx_next   = idx_reg + 1'b1;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = S_PICK;
                end
                if (sts.explore)
                begin
                    idx_next   = '0;
                    state_next = S_NXT;
                    rv_next    = 1'b0;
                    cmd.rd_cur = 1'b0;
                    cmd.scan_cur = 1'b0;
                end
            end
            S_PICK:
            begin
                cmd.pick_cur = rv_reg;
                cmd.first    = rv_reg && (idx_reg == NW'(1));
                if (idx_reg < n_used)
                begin
                    cmd.rd_cur = 1'b1;
                    rv_next    = 1'b1;
                    idx_next   = idx_reg + 1'b1;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = S_NXT;
                end
            end
            S_NXT:
            begin
                cmd.scan_nxt = rv_reg;
                cmd.first    = rv_reg && (idx_reg == NW'(1));
                if (!sts.upd_ok)
                begin
                    state_next = S_WR;
                end
                else if (idx_reg < n_used)
                begin
                    cmd.rd_nxt = 1'b1;
                    rv_next    = 1'b1;
                    idx_next   = idx_reg + 1'b1;
                end
                else
                begin
                    cmd.rd_old = 1'b1;
                    state_next = S_OLD;
                end
            end
            S_OLD:
            begin
                cmd.take_old = 1'b1;
                state_next   = S_MULG;
            end
            S_MULG:
            begin
                cmd.mul_g  = 1'b1;
                state_next = S_MULA;
            end
            S_MULA:
            begin
                cmd.mul_a  = 1'b1;
                state_next = S_WR;
            end
            S_WR:
            begin
                cmd.mul_e  = 1'b1;
                cmd.do_upd = sts.upd_ok;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                cmd.wr_q   = 1'b1;
                cmd.do_upd = sts.upd_ok;
                if (!ov_reg || out_ready)
                begin
                    cmd.publish = 1'b1;
                    ov_next     = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            idx_reg   <= '0;
            rv_reg    <= 1'b0;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            rv_reg    <= rv_next;
            clr_reg   <= clr_next;
            ov_reg    <= ov_next;
        end
    end
endmodule

// ===== src/tqla_dp.sv =====
`timescale 1ns / 1ps
module tqla_dp #(
    parameter int STATE_COUNT = 64,
    parameter int ACTION_MAX  = 4,
    parameter int AW = 8,
    parameter int NW = 3,
    parameter int SW = 6,
    parameter int XW = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tqla_pkg::tqla_cmd_t  cmd,
    output tqla_pkg::tqla_sts_t  sts,
    input  logic [NW-1:0]        idx,
    input  logic [AW-1:0]        clr_addr,
    input  logic [5:0]           current_state,
    input  logic [5:0]           following_state,
    input  logic signed [31:0]   reward_value,
    input  logic [15:0]          explore_draw,
    input  logic [15:0]          pick_draw,
    input  logic                 cfg_we,
    input  logic [tqla_pkg::CFG_IW-1:0] cfg_index,
    input  logic [tqla_pkg::CFG_W-1:0]  cfg_data,
    output logic [NW-1:0]        n_used,
    output logic [1:0]           chosen_action,
    output logic                 explored,
    output logic                 update_done,
    output logic signed [31:0]   updated_value
);
    localparam int DEPTH = STATE_COUNT * ACTION_MAX;

    // configuration
    logic [2:0]  cnt_reg;
    logic [15:0] alpha_reg, gamma_reg, decay_reg;
    logic [16:0] floor_reg, start_reg, eps_reg;

    // pending decision
    logic [SW-1:0] pst_reg;
    logic [XW-1:0] pact_reg;
    logic          pval_reg;

    // transaction
    logic [SW-1:0] cur_reg, nxt_reg;
    logic signed [31:0] rew_reg;
    logic [15:0] pdraw_reg;
    logic        expl_reg;
    logic [XW-1:0] act_reg;
    logic signed [31:0] best_reg, maxq_reg, old_reg;
    logic [NW-1:0] ties_reg, seen_reg, pick_reg, ridx_reg;
    logic signed [49:0] gq_reg;
    logic signed [66:0] nq_reg;
    logic [16:0] lvl_reg;

    logic [AW-1:0] raddr, waddr;
    logic          we;
    logic [31:0]   wdata, rdata;
    logic signed [31:0] q;

    always_comb
    begin
        if (cnt_reg == 3'd0)
            n_used = NW'(1);
        else if (32'(cnt_reg) > ACTION_MAX)
            n_used = NW'(ACTION_MAX);
        else
            n_used = NW'(cnt_reg);
    end

    function automatic logic [SW-1:0] clamp_s(input logic [5:0] s);
        if (32'(s) >= STATE_COUNT)
            return SW'(STATE_COUNT - 1);
        return SW'(s);
    endfunction

    function automatic logic [AW-1:0] ent(input logic [SW-1:0] s, input logic [NW-1:0] a);
        return AW'(32'(s) * ACTION_MAX + 32'(a));
    endfunction

    logic signed [31:0] newq_sat;
    logic signed [66:0] nq_r;
    logic [33:0] decay_p;
    logic [16:0] decay_l;
    logic signed [33:0] diff;

    assign q = rdata;
    assign diff = 34'(rew_reg) + 34'((gq_reg + 50'sd32768) >>> 16) - 34'(old_reg);
    assign nq_r = 67'(old_reg) + 67'((nq_reg + 67'sd32768) >>> 16);
    always_comb
    begin
        if (nq_r > 67'sd2147483647)
            newq_sat = 32'sh7fffffff;
        else if (nq_r < -67'sd2147483648)
            newq_sat = 32'sh80000000;
        else
            newq_sat = nq_r[31:0];
    end
    assign decay_p = 34'(eps_reg) * 34'(decay_reg) + 34'd32768;
    assign decay_l = (decay_p[32:16] < floor_reg) ? floor_reg : decay_p[32:16];

    assign sts.explore = expl_reg;
    assign sts.upd_ok  = pval_reg && (NW'(pact_reg) < n_used);

    always_comb
    begin
        raddr = ent(cur_reg, idx);
        if (cmd.rd_nxt)
            raddr = ent(nxt_reg, idx);
        else if (cmd.rd_old)
            raddr = ent(pst_reg, NW'(pact_reg));
        we    = cmd.clr_wr || (cmd.wr_q && cmd.do_upd);
        waddr = cmd.clr_wr ? clr_addr : ent(pst_reg, NW'(pact_reg));
        wdata = cmd.clr_wr ? 32'd0 : newq_sat;
    end

    tqla_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= tqla_pkg::ACTION_COUNT_RST;
            alpha_reg <= tqla_pkg::LEARN_RATE_RST;
            gamma_reg <= tqla_pkg::DISCOUNT_RST;
            floor_reg <= tqla_pkg::EXPLORE_FLOOR_RST;
            decay_reg <= tqla_pkg::EXPLORE_DECAY_RST;
            start_reg <= tqla_pkg::EXPLORE_START_RST;
            eps_reg   <= tqla_pkg::EXPLORE_START_RST;
            pst_reg   <= '0;
            pact_reg  <= '0;
            pval_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    tqla_pkg::REG_ACTION_COUNT:  cnt_reg   <= cfg_data[2:0];
                    tqla_pkg::REG_LEARN_RATE:    alpha_reg <= cfg_data[15:0];
                    tqla_pkg::REG_DISCOUNT:      gamma_reg <= cfg_data[15:0];
                    tqla_pkg::REG_EXPLORE_FLOOR: floor_reg <= cfg_data;
                    tqla_pkg::REG_EXPLORE_DECAY: decay_reg <= cfg_data[15:0];
                    tqla_pkg::REG_EXPLORE_START:
                    begin
                        start_reg <= cfg_data;
                        eps_reg   <= cfg_data;
                    end
                    default: ;
                endcase
            end
            if (cmd.wr_q && cmd.publish)
            begin
                pst_reg  <= cur_reg;
                pact_reg <= act_reg;
                pval_reg <= 1'b1;
                eps_reg  <= lvl_reg;
            end
        end
    end

    logic [16+NW-1:0] tp;
    assign tp = 16'(pdraw_reg) * (16+NW)'(1) * ties_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cur_reg   <= clamp_s(current_state);
            nxt_reg   <= clamp_s(following_state);
            rew_reg   <= reward_value;
            pdraw_reg <= pick_draw;
            expl_reg  <= 17'(explore_draw) < eps_reg;
            act_reg   <= XW'(((16+NW)'(pick_draw) * (16+NW)'(n_used)) >> 16);
            gq_reg    <= '0;
            nq_reg    <= '0;
            seen_reg  <= '0;
        end
        ridx_reg <= idx;
        if (cmd.scan_cur)
        begin
            if (cmd.first || q > best_reg)
            begin
                best_reg <= q;
                ties_reg <= NW'(1);
            end
            else if (q == best_reg)
                ties_reg <= ties_reg + 1'b1;
        end
        if (cmd.pick_cur)
        begin
            if (cmd.first)
                pick_reg <= NW'(tp >> 16);
            if (q == best_reg)
            begin
                // ridx_reg holds the action index of the returned entry
                if (seen_reg == (cmd.first ? NW'(tp >> 16) : pick_reg))
                    act_reg <= XW'(ridx_reg);
                seen_reg <= seen_reg + 1'b1;
            end
        end
        if (cmd.scan_nxt && (cmd.first || q > maxq_reg))
            maxq_reg <= q;
        if (cmd.take_old)
            old_reg <= q;
        if (cmd.mul_g)
            gq_reg <= 50'($signed({1'b0, gamma_reg})) * 50'(maxq_reg);
        if (cmd.mul_a)
            nq_reg <= 67'($signed({1'b0, alpha_reg})) * 67'(diff);
        if (cmd.mul_e)
            lvl_reg <= decay_l;
        if (cmd.publish)
        begin
            chosen_action <= act_reg;
            explored      <= expl_reg;
            update_done   <= cmd.do_upd;
            updated_value <= cmd.do_upd ? newq_sat : 32'sd0;
        end
    end
endmodule
